@@ rtl/core/bspw_pkg.sv @@
`timescale 1ns / 1ps

package bspw_pkg;

  // fixed field widths
  localparam int unsigned CountW = 13;
  localparam int unsigned IndexW = 12;
  localparam int unsigned CoordW = 32;
  localparam int unsigned ChildW = 16;
  localparam int unsigned LeafW  = 15;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned ProdW  = 32;

  // bit 15 of a child word marks a leaf
  localparam int unsigned LeafBit = 15;

  // beat kinds on the input channel
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // one stored partition node, 160 bits
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [ChildW-1:0] front;
    logic [ChildW-1:0] back;
  } node_t;

endpackage

@@ rtl/core/bspw_in_if.sv @@
`timescale 1ns / 1ps

interface bspw_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic        [11:0] node_index;
  logic signed [31:0] part_x;
  logic signed [31:0] part_y;
  logic signed [31:0] part_dx;
  logic signed [31:0] part_dy;
  logic        [15:0] front_child;
  logic        [15:0] back_child;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;

  modport source (
    output valid, mode, node_index, part_x, part_y, part_dx, part_dy,
           front_child, back_child, query_x, query_y,
    input  ready
  );

  modport sink (
    input  valid, mode, node_index, part_x, part_y, part_dx, part_dy,
           front_child, back_child, query_x, query_y,
    output ready
  );
endinterface

@@ rtl/core/bspw_out_if.sv @@
`timescale 1ns / 1ps

interface bspw_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] leaf_index;
  logic        walk_error;

  modport source (
    output valid, leaf_index, walk_error,
    input  ready
  );

  modport sink (
    input  valid, leaf_index, walk_error,
    output ready
  );
endinterface

@@ rtl/core/bspw_cfg_if.sv @@
`timescale 1ns / 1ps

interface bspw_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;

  modport source (
    output valid, data,
    input  ready
  );

  modport sink (
    input  valid, data,
    output ready
  );
endinterface

@@ rtl/core/bspw_node_mem.sv @@
`timescale 1ns / 1ps

module bspw_node_mem
  import bspw_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  node_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output node_t         rd_data
);

  node_t mem [DEPTH];
  node_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/bspw_mul.sv @@
`timescale 1ns / 1ps

module bspw_mul
  import bspw_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [HalfW-1:0] a,
  input  logic signed [HalfW-1:0] b,
  output logic signed [ProdW-1:0] p
);

  logic signed [ProdW-1:0] p_r;

  // shared signed 16x16 multiplier with registered product
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

@@ rtl/core/bsp_point_in_leaf_walk.sv @@
`timescale 1ns / 1ps

// channel  | dir | beat contents
// ---------+-----+-----------------------------------------------------------
// in_bus   | in  | mode, node_index, part_x/y/dx/dy, front/back_child, query
// out_bus  | out | leaf_index, walk_error (one beat per query, none per write)
// cfg_bus  | in  | node_count, always ready
//
// a query on an empty tree goes straight to its result; otherwise it visits
// nodes from the root, reading each one from memory and deciding an
// axis-aligned line directly or a slanted one with two passes through the
// shared multiplier
// reset clears node_count and the control state; the node table is undefined
// until written and needs no clearing
// in_ready is low from a query beat until its result is in the output
// register; a full output register stalls only the end of the next query

module bsp_point_in_leaf_walk
  import bspw_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  bspw_in_if.sink           in_bus,
  bspw_out_if.source        out_bus,
  bspw_cfg_if.sink          cfg_bus
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_MUL_L = 3'd3;
  localparam logic [2:0] S_MUL_R = 3'd4;
  localparam logic [2:0] S_SIDE  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [ChildW-1:0] TableLimit = ChildW'(MAX_NODES);

  logic [2:0]              state_r, state_nxt;
  logic [CountW-1:0]       node_count_r;
  logic [ChildW-1:0]       cur_r, cur_nxt;
  logic [CountW-1:0]       steps_r, steps_nxt;
  logic [CoordW-1:0]       qx_r, qy_r;
  logic [CoordW-1:0]       offx_r, offy_r;
  logic signed [ProdW-1:0] left_r;
  logic [LeafW-1:0]        res_leaf_r, res_leaf_nxt;
  logic                    res_err_r, res_err_nxt;
  logic                    out_valid_r;
  logic [LeafW-1:0]        out_leaf_r;
  logic                    out_err_r;

  logic                    in_fire;
  logic                    wr_fire;
  logic                    wr_in_range;
  logic                    rd_en;
  logic                    mul_en;
  logic signed [HalfW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic                    out_free;
  logic                    cur_bad;
  node_t                   wr_node;
  node_t                   node;
  logic [CoordW-1:0]       offx_cur, offy_cur;
  logic                    side;

  // node table
  assign wr_in_range = {4'b0, in_bus.node_index} < TableLimit;
  assign in_fire     = in_bus.valid & in_bus.ready;
  assign wr_fire     = in_fire & (in_bus.mode == MODE_WRITE) & wr_in_range;

  assign wr_node.x     = in_bus.part_x;
  assign wr_node.y     = in_bus.part_y;
  assign wr_node.dx    = in_bus.part_dx;
  assign wr_node.dy    = in_bus.part_dy;
  assign wr_node.front = in_bus.front_child;
  assign wr_node.back  = in_bus.back_child;

  bspw_node_mem #(
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_fire),
    .wr_addr (AW'({4'b0, in_bus.node_index})),
    .wr_data (wr_node),
    .rd_en   (rd_en),
    .rd_addr (AW'(cur_r)),
    .rd_data (node)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = node.dy[CoordW-1 -: HalfW];
    mul_b = offx_r[CoordW-1 -: HalfW];
    if (state_r == S_MUL_R) begin
      mul_a = offy_r[CoordW-1 -: HalfW];
      mul_b = node.dx[CoordW-1 -: HalfW];
    end
  end

  assign mul_en = (state_r == S_MUL_L) | (state_r == S_MUL_R);

  bspw_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // offsets from the partition origin, wrapping
  assign offx_cur = qx_r - node.x;
  assign offy_cur = qy_r - node.y;

  // bounds and length check on the node about to be read
  assign cur_bad = (cur_r >= {3'b0, node_count_r}) | (cur_r >= TableLimit) |
                   (steps_r >= node_count_r);

  assign rd_en    = (state_r == S_CHECK) & ~cur_r[LeafBit] & ~cur_bad;
  assign out_free = ~out_valid_r | out_bus.ready;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    steps_nxt    = steps_r;
    res_leaf_nxt = res_leaf_r;
    res_err_nxt  = res_err_r;
    side         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_bus.mode == MODE_QUERY)) begin
          steps_nxt    = '0;
          cur_nxt      = ChildW'(node_count_r - CountW'(1));
          res_leaf_nxt = '0;
          res_err_nxt  = 1'b0;
          if (node_count_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (cur_r[LeafBit]) begin
          res_leaf_nxt = cur_r[LeafW-1:0];
          state_nxt    = S_DONE;
        end else if (cur_bad) begin
          res_leaf_nxt = '0;
          res_err_nxt  = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          steps_nxt = steps_r + CountW'(1);
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        // vertical and horizontal lines are decided directly
        if (node.dx == '0) begin
          if ($signed(qx_r) <= $signed(node.x)) begin
            side = $signed(node.dy) > 0;
          end else begin
            side = $signed(node.dy) < 0;
          end
          cur_nxt   = side ? node.back : node.front;
          state_nxt = S_CHECK;
        end else if (node.dy == '0) begin
          if ($signed(qy_r) <= $signed(node.y)) begin
            side = $signed(node.dx) < 0;
          end else begin
            side = $signed(node.dx) > 0;
          end
          cur_nxt   = side ? node.back : node.front;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_MUL_L;
        end
      end
      S_MUL_L: begin
        state_nxt = S_MUL_R;
      end
      S_MUL_R: begin
        state_nxt = S_SIDE;
      end
      S_SIDE: begin
        // multiplier now holds the right-hand product
        side      = ~(mul_p < left_r);
        cur_nxt   = side ? node.back : node.front;
        state_nxt = S_CHECK;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_bus.valid && cfg_bus.ready) begin
        node_count_r <= cfg_bus.data;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk datapath registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    res_leaf_r <= res_leaf_nxt;
    res_err_r  <= res_err_nxt;
    if (in_fire) begin
      qx_r <= in_bus.query_x;
      qy_r <= in_bus.query_y;
    end
    if (state_r == S_FETCH) begin
      offx_r <= offx_cur;
      offy_r <= offy_cur;
    end
    if (state_r == S_MUL_R) begin
      left_r <= mul_p;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_leaf_r <= res_leaf_r;
      out_err_r  <= res_err_r;
    end
  end

  assign in_bus.ready       = (state_r == S_IDLE);
  assign cfg_bus.ready      = 1'b1;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.leaf_index = out_leaf_r;
  assign out_bus.walk_error = out_err_r;

endmodule

@@ tb/sv/bsp_point_in_leaf_walk_tb.sv @@
`timescale 1ns / 1ps

module bsp_point_in_leaf_walk_tb;
  import bspw_pkg::*;

  localparam int unsigned MaxNodes    = 4096;
  localparam int unsigned SettleTicks = 8;
  localparam int unsigned RandomBeats = 1750;

  // one beat on the input channel
  typedef struct {
    logic              mode;
    logic [IndexW-1:0] node_index;
    node_t             node;
    logic [CoordW-1:0] query_x;
    logic [CoordW-1:0] query_y;
  } in_beat_t;

  // answer of one point query
  typedef struct {
    logic [LeafW-1:0] leaf;
    logic             err;
  } leaf_answer_t;

  // mirror of the node table plus the queue of leaf answers still due
  class leaf_scoreboard;
    node_t        nodes [MaxNodes];
    int unsigned  node_count;
    leaf_answer_t leaves_due [$];
    int unsigned  errors;
    int unsigned  queries;
    int unsigned  walk_errors;
    int unsigned  node_writes;

    // signed integer part of a 16.16 word
    function longint int_part(logic [31:0] v);
      return longint'($signed(v[31:16]));
    endfunction

    // 0 = front side of the partition line, 1 = back side
    function bit side_of(logic [31:0] qx, logic [31:0] qy, node_t n);
      logic signed [31:0] sx, sy, ox, oy, ddx, ddy;
      longint             lhs, rhs;
      sx  = qx;
      sy  = qy;
      ox  = n.x;
      oy  = n.y;
      ddx = n.dx;
      ddy = n.dy;
      // axis-aligned lines compare against the origin directly
      if (ddx == 0) return (sx <= ox) ? (ddy > 0) : (ddy < 0);
      if (ddy == 0) return (sy <= oy) ? (ddx < 0) : (ddx > 0);
      // slanted line: products of integer parts, offsets wrap at 32 bits
      lhs = int_part(n.dy) * int_part(qx - n.x);
      rhs = int_part(qy - n.y) * int_part(n.dx);
      return (rhs < lhs) ? 1'b0 : 1'b1;
    endfunction

    // walk from the root down to a leaf word
    function leaf_answer_t locate_leaf(logic [31:0] qx, logic [31:0] qy);
      leaf_answer_t ans;
      int unsigned  cur;
      int unsigned  steps;
      ans.leaf = '0;
      ans.err  = 1'b0;
      if (node_count == 0) return ans;
      cur   = node_count - 1;
      steps = 0;
      while (cur[LeafBit] == 1'b0) begin
        if (cur >= node_count || cur >= MaxNodes || steps >= node_count) begin
          ans.err = 1'b1;
          return ans;
        end
        steps++;
        cur = side_of(qx, qy, nodes[cur]) ? nodes[cur].back : nodes[cur].front;
      end
      ans.leaf = cur[LeafW-1:0];
      return ans;
    endfunction

    function void note_beat(in_beat_t b);
      leaf_answer_t ans;
      if (b.mode == MODE_WRITE) begin
        nodes[b.node_index] = b.node;
        node_writes++;
      end else begin
        ans = locate_leaf(b.query_x, b.query_y);
        leaves_due.push_back(ans);
        queries++;
        if (ans.err) walk_errors++;
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_leaf(logic [LeafW-1:0] leaf, logic err);
      leaf_answer_t want;
      if (leaves_due.size() == 0) begin
        report($sformatf("unexpected result beat leaf %0d err %0b", leaf, err));
        return;
      end
      want = leaves_due.pop_front();
      if (leaf !== want.leaf)
        report($sformatf("leaf_index %0d, want %0d", leaf, want.leaf));
      if (err !== want.err)
        report($sformatf("walk_error %0b, want %0b", err, want.err));
    endtask

    function int unsigned pending();
      return leaves_due.size();
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n;
  bspw_in_if      in_bus ();
  bspw_out_if     out_bus ();
  bspw_cfg_if     cfg_bus ();
  leaf_scoreboard sb;
  bit             steady;
  int unsigned    beats_sent;
  int unsigned    count_writes;

  bsp_point_in_leaf_walk #(
    .MAX_NODES(MaxNodes)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always #10 clk = ~clk;

  // watch every handshake and feed the scoreboard
  always @(posedge clk) begin : watch
    in_beat_t seen;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.node_count = cfg_bus.data;
        count_writes++;
      end
      if (in_bus.valid && in_bus.ready) begin
        seen.mode       = in_bus.mode;
        seen.node_index = in_bus.node_index;
        seen.node.x     = in_bus.part_x;
        seen.node.y     = in_bus.part_y;
        seen.node.dx    = in_bus.part_dx;
        seen.node.dy    = in_bus.part_dy;
        seen.node.front = in_bus.front_child;
        seen.node.back  = in_bus.back_child;
        seen.query_x    = in_bus.query_x;
        seen.query_y    = in_bus.query_y;
        sb.note_beat(seen);
      end
      if (out_bus.valid && out_bus.ready)
        sb.check_leaf(out_bus.leaf_index, out_bus.walk_error);
    end
  end

  // result back-pressure
  always @(posedge clk) out_bus.ready <= steady || ($urandom_range(0, 99) >= 6);

  // present one beat and hold it until accepted
  task automatic send_beat(in_beat_t b);
    if (!steady && $urandom_range(0, 99) < 6) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= b.mode;
    in_bus.node_index  <= b.node_index;
    in_bus.part_x      <= b.node.x;
    in_bus.part_y      <= b.node.y;
    in_bus.part_dx     <= b.node.dx;
    in_bus.part_dy     <= b.node.dy;
    in_bus.front_child <= b.node.front;
    in_bus.back_child  <= b.node.back;
    in_bus.query_x     <= b.query_x;
    in_bus.query_y     <= b.query_y;
    do @(posedge clk); while (!in_bus.ready);
    beats_sent++;
  endtask

  // stop sending and wait for every outstanding leaf answer
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic set_node_count(int unsigned n);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= CountW'(n);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_node(int unsigned slot, node_t n);
    in_beat_t b;
    b.mode       = MODE_WRITE;
    b.node_index = IndexW'(slot);
    b.node       = n;
    b.query_x    = $urandom();
    b.query_y    = $urandom();
    send_beat(b);
  endtask

  task automatic query_point(logic [31:0] qx, logic [31:0] qy);
    in_beat_t b;
    b.mode       = MODE_QUERY;
    b.node_index = IndexW'($urandom());
    b.node       = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    b.query_x    = qx;
    b.query_y    = qy;
    send_beat(b);
  endtask

  function automatic node_t make_node(logic [31:0] x, logic [31:0] y, logic [31:0] dx,
                                      logic [31:0] dy, logic [15:0] front,
                                      logic [15:0] back);
    node_t n;
    n.x     = x;
    n.y     = y;
    n.dx    = dx;
    n.dy    = dy;
    n.front = front;
    n.back  = back;
    return n;
  endfunction

  // 16.16 word leaning toward the extremes and small magnitudes
  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom();
    endcase
  endfunction

  // child word: a leaf, a lower node, or with bad_link any non-leaf index
  function automatic logic [15:0] rnd_child(int unsigned slot, bit bad_link);
    int unsigned lo;
    if (bad_link) return 16'($urandom_range(0, 16'h7FFF));
    if (slot == 0 || $urandom_range(0, 99) < 35) begin
      case ($urandom_range(0, 7))
        0: return 16'h8000;
        1: return 16'hFFFF;
        default: return 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
      endcase
    end
    // half the links point just below, which builds deep chains
    lo = ($urandom_range(0, 1) == 0 || slot < 4) ? 0 : slot - 4;
    return 16'($urandom_range(lo, slot - 1));
  endfunction

  function automatic node_t rnd_node(int unsigned slot, bit bad_link);
    node_t n;
    bit    which;
    n.x  = rnd_word();
    n.y  = rnd_word();
    n.dx = rnd_word();
    n.dy = rnd_word();
    case ($urandom_range(0, 9))
      0, 1: n.dx = '0;
      2, 3: n.dy = '0;
      4: begin
        n.dx = '0;
        n.dy = '0;
      end
      5: n.dx = $urandom_range(1, 16'hFFFF);
      default: ;
    endcase
    which   = $urandom_range(0, 1);
    n.front = rnd_child(slot, bad_link && !which);
    n.back  = rnd_child(slot, bad_link && which);
    return n;
  endfunction

  task automatic load_tree(int unsigned n);
    for (int unsigned i = 0; i < n; i++) write_node(i, rnd_node(i, 1'b0));
  endtask

  // timeout
  initial begin
    #100_000_000;
    $display("bsp_point_in_leaf_walk regression: fail");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned start;
    int unsigned pick;
    sb                 = new();
    steady             = 1'b0;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.mode        = MODE_WRITE;
    in_bus.node_index  = '0;
    in_bus.part_x      = '0;
    in_bus.part_y      = '0;
    in_bus.part_dx     = '0;
    in_bus.part_dy     = '0;
    in_bus.front_child = '0;
    in_bus.back_child  = '0;
    in_bus.query_x     = '0;
    in_bus.query_y     = '0;
    out_bus.ready      = 1'b1;
    cfg_bus.valid      = 1'b0;
    cfg_bus.data       = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty tree answers leaf 0
    query_point(32'h8000_0000, 32'h7FFF_FFFF);
    // vertical line through x = 1.0, at, left and right of it
    write_node(0, make_node(32'h0001_0000, 0, 0, 32'h0001_0000, 16'hFFFF, 16'h8000));
    set_node_count(1);
    query_point(32'h8000_0000, 0);
    query_point(32'h0001_0000, 0);
    query_point(32'h7FFF_FFFF, 0);
    // horizontal line with direction toward -x
    write_node(0, make_node(0, 32'h0001_0000, 32'hFFFF_0000, 0, 16'h8001, 16'h8002));
    query_point(0, 32'h8000_0000);
    query_point(0, 32'h0001_0000);
    query_point(0, 32'h7FFF_FFFF);
    // slanted line where the offset from the origin wraps
    write_node(0, make_node(32'h7FFF_0000, 32'h7FFF_0000, 32'h0001_0000, 32'h0001_0000,
                            16'h8003, 16'h8004));
    query_point(32'h8000_0000, 32'h7FFF_0000);
    query_point(32'h7FFF_0000, 32'h8000_0000);
    // zero direction
    write_node(0, make_node(0, 0, 0, 0, 16'h8005, 16'h8006));
    query_point(32'h8000_0000, 0);
    query_point(32'h7FFF_FFFF, 0);
    // child past node_count and past the largest table
    write_node(0, make_node(0, 0, 0, 32'h0001_0000, 16'h0005, 16'h7FFF));
    query_point(32'h8000_0000, 0);
    query_point(32'h7FFF_FFFF, 0);
    // self loop runs out of steps
    write_node(0, make_node(0, 0, 0, 32'h0001_0000, 16'h0000, 16'h0000));
    query_point(0, 0);
    // two levels, fraction-only direction gives zero products
    write_node(1, make_node(0, 0, 32'h0000_8000, 32'h0000_4000, 16'h8009, 16'h0000));
    set_node_count(2);
    query_point(32'h0012_3456, 32'hFFED_CBA9);

    // random phases over small trees
    start = beats_sent;
    phase = 0;
    while (beats_sent - start < RandomBeats) begin
      steady = (phase == 3 || phase == 9);
      case (phase)
        0: n = 0;
        1: n = 1;
        2: n = 2;
        default: n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6)
                                                   : $urandom_range(3, 40);
      endcase
      load_tree(n);
      set_node_count(n);
      repeat ($urandom_range(30, 70)) begin
        pick = $urandom_range(0, 99);
        if (pick < 12 && n != 0)
          write_node($urandom_range(0, n - 1),
                     rnd_node($urandom_range(0, n - 1), $urandom_range(0, 99) < 30));
        else if (pick < 15)
          write_node($urandom_range(0, MaxNodes - 1), rnd_node($urandom_range(0, 64), 1'b1));
        else if (pick < 17)
          drain();
        else
          query_point(rnd_word(), rnd_word());
      end
      phase++;
    end

    // largest node_count, only the root is ever read
    steady = 1'b0;
    set_node_count(MaxNodes);
    // root loops on itself until the step limit
    write_node(MaxNodes - 1, make_node(0, 0, 0, 32'h0001_0000, 16'(MaxNodes - 1),
                                       16'(MaxNodes - 1)));
    query_point(32'h8000_0000, 0);
    query_point(32'h7FFF_FFFF, 0);
    // child equal to node_count is outside the table
    write_node(MaxNodes - 1, make_node(0, 0, 0, 32'h0001_0000, 16'(MaxNodes), 16'h8000));
    query_point(32'h7FFF_FFFF, 0);
    set_node_count(0);
    query_point(rnd_word(), rnd_word());

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d node writes and %0d point queries across %0d node_count settings",
             sb.node_writes, sb.queries, count_writes);
    $display("%0d walks ended in a leaf, %0d raised walk_error, %0d mismatches",
             sb.queries - sb.walk_errors, sb.walk_errors, sb.errors);
    if (sb.errors == 0)
      $display("bsp_point_in_leaf_walk regression: pass");
    else
      $display("bsp_point_in_leaf_walk regression: fail");
    $finish;
  end

endmodule
